// ===== rtl/session_key_table_assert.svh =====
// Assertion macros shared by the session key table checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SESSION_KEY_TABLE_ASSERT_SVH
`define SESSION_KEY_TABLE_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define SKT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen, checked out of reset.
`define SKT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/skt_pkg.sv =====
// Package for the session key table: item and result structs, queue entry,
// status and command codes, back-end state type. No dependencies.
package skt_pkg;

    localparam int          WIN_W     = 9;
    localparam logic [8:0]  WIN_RESET = 9'd60;

    localparam logic        CMD_STORE  = 1'b0;
    localparam logic        CMD_LOOKUP = 1'b1;

    localparam logic [2:0]  ST_STORED   = 3'd0;
    localparam logic [2:0]  ST_MISMATCH = 3'd1;
    localparam logic [2:0]  ST_STALE    = 3'd2;
    localparam logic [2:0]  ST_HIT      = 3'd3;
    localparam logic [2:0]  ST_MISS     = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  device_id;
        logic [7:0]  authority_id;
        logic [7:0]  sealed_device_id;
        logic [7:0]  sealed_authority_id;
        logic [7:0]  token_time;
        logic [7:0]  now_seconds;
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
    } skt_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  slot_index;
        logic        overwrote_full;
        logic [7:0]  found_authority;
        logic [63:0] data_key_low;
        logic [63:0] data_key_high;
    } skt_result_t;

    // Classification done at the front.
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_LOOKUP,
        KIND_MISMATCH,
        KIND_STALE
    } skt_kind_t;

    typedef struct packed {
        skt_kind_t   kind;
        logic [7:0]  device_id;
        logic [7:0]  authority_id;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } skt_entry_t;

    typedef struct packed {
        logic       valid;
        skt_entry_t entry;
    } skt_push_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_RESOLVE,
        BK_READ
    } skt_back_state_t;

endpackage

// ===== rtl/skt_front.sv =====
// Front end: takes items, holds the freshness window register and classifies
// each item as store, lookup, header mismatch or stale. Uses skt_pkg.
module skt_front
    import skt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  skt_item_t         item,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_wdata,
    input  logic              full,
    output logic              busy,
    output skt_push_t         push
);

    logic [WIN_W-1:0] window_reg;
    logic [7:0]       elapsed;
    skt_kind_t        kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    // mod-256 wrap comes from the 8-bit subtract
    assign elapsed = item.now_seconds - item.token_time;

    always_comb
    begin
        if (item.cmd == CMD_LOOKUP)
        begin
            kind = KIND_LOOKUP;
        end
        else if ((item.sealed_device_id != item.device_id) ||
                 (item.sealed_authority_id != item.authority_id))
        begin
            kind = KIND_MISMATCH;
        end
        else if ({1'b0, elapsed} >= window_reg)
        begin
            kind = KIND_STALE;
        end
        else
        begin
            kind = KIND_STORE;
        end
    end

    assign busy                     = full;
    assign push.valid               = start && !full;
    assign push.entry.kind          = kind;
    assign push.entry.device_id     = item.device_id;
    assign push.entry.authority_id  = item.authority_id;
    assign push.entry.key_low       = item.key_word_0;
    assign push.entry.key_high      = item.key_word_1;

endmodule

// ===== rtl/skt_queue.sv =====
// Two-entry queue between front and back ends of the session key table.
// Uses skt_pkg for the entry type.
module skt_queue
    import skt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  skt_push_t  push,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output skt_entry_t head
);

    skt_entry_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.entry;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/skt_back.sv =====
// Back end: slot table (registered device ids, valid marks, key memory),
// match/free search and result register. Uses skt_pkg.
module skt_back
    import skt_pkg::*;
#(
    parameter int SLOT_COUNT = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  skt_entry_t  head,
    output logic        pop,
    output logic        done,
    output skt_result_t result
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // only key bytes 0..15 are ever returned, so only those are kept
    typedef struct packed {
        logic [7:0]  authority;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } slot_data_t;

    skt_back_state_t       state_reg;
    skt_back_state_t       state_next;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [7:0]            dev_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] match_vec_reg;
    logic [SLOT_COUNT-1:0] free_vec_reg;
    slot_data_t            mem [SLOT_COUNT];
    slot_data_t            rd_data_reg;
    logic                  hit_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  done_reg;
    logic                  done_next;
    skt_result_t           result_reg;
    skt_result_t           result_next;

    logic                  match_any;
    logic                  free_any;
    logic [SLOT_W-1:0]     match_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     store_slot;
    logic                  store_full;
    logic                  cap_en;
    logic                  wr_en;
    logic                  rd_en;
    logic                  is_reject;

    assign match_any = |match_vec_reg;
    assign free_any  = |free_vec_reg;

    // lowest set bit wins
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (match_vec_reg[i])
            begin
                match_idx = SLOT_W'(i);
            end
            if (free_vec_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign store_full = !match_any && !free_any;
    assign store_slot = match_any ? match_idx : (free_any ? free_idx : '0);
    assign is_reject  = (head.kind == KIND_MISMATCH) || (head.kind == KIND_STALE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && !is_reject)
                begin
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH:
            begin
                state_next = BK_RESOLVE;
            end
            BK_RESOLVE:
            begin
                state_next = (head.kind == KIND_STORE) ? BK_IDLE : BK_READ;
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        done_next   = 1'b0;
        result_next = '0;
        cap_en      = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && is_reject)
                begin
                    pop                = 1'b1;
                    done_next          = 1'b1;
                    result_next.status = (head.kind == KIND_MISMATCH) ? ST_MISMATCH
                                                                       : ST_STALE;
                end
            end
            BK_MATCH:
            begin
                cap_en = 1'b1;
            end
            BK_RESOLVE:
            begin
                if (head.kind == KIND_STORE)
                begin
                    wr_en                      = 1'b1;
                    pop                        = 1'b1;
                    done_next                  = 1'b1;
                    result_next.status         = ST_STORED;
                    result_next.slot_index     = 7'(store_slot);
                    result_next.overwrote_full = store_full;
                end
                else
                begin
                    rd_en = match_any;
                end
            end
            BK_READ:
            begin
                pop       = 1'b1;
                done_next = 1'b1;
                if (hit_reg)
                begin
                    result_next.status          = ST_HIT;
                    result_next.slot_index      = 7'(slot_reg);
                    result_next.found_authority = rd_data_reg.authority;
                    result_next.data_key_low    = rd_data_reg.key_low;
                    result_next.data_key_high   = rd_data_reg.key_high;
                end
                else
                begin
                    result_next.status = ST_MISS;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_en)
            begin
                valid_reg[store_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                match_vec_reg[i] <= valid_reg[i] && (dev_reg[i] == head.device_id);
            end
            free_vec_reg <= ~valid_reg;
        end
        if (wr_en)
        begin
            dev_reg[store_slot] <= head.device_id;
        end
        if (state_reg == BK_RESOLVE)
        begin
            hit_reg  <= match_any;
            slot_reg <= match_idx;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[store_slot] <= '{authority: head.authority_id,
                                 key_low:   head.key_low,
                                 key_high:  head.key_high};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[match_idx];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/session_key_table.sv =====
// Top level of the gateway session key table: front end, queue, back end.
// Depends on skt_pkg, skt_front, skt_queue and skt_back.
//
//  channel   handshake          payload        notes
//  -------   ----------------   ------------   ------------------------------
//  item in   start / busy       item           taken when start & !busy
//  result    done (strobe)      result         valid for one cycle only
//  config    cfg_we             cfg_wdata      freshness window, no wait
//
// Steps: header-mismatch and stale items are answered from the back end's
// idle state; a store does an id compare over all slots, then a priority
// pick and table write; a lookup does compare, pick and key memory read.
// The back end's compare/pick/read sequence sets the rate; the 2-entry queue
// lets the front keep taking items while the back end works.
// Reset clears all valid marks at once; no clearing pass. The receiver cannot
// stall, so busy rises only when the queue holds two items.
module session_key_table
    import skt_pkg::*;
#(
    parameter int SLOT_COUNT = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  skt_item_t         item,
    output logic              done,
    output skt_result_t       result,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_wdata
);

    skt_push_t  push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    skt_entry_t q_head;

    // front: window check and header compare happen at accept time
    skt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .full      (q_full),
        .busy      (busy),
        .push      (push)
    );

    // items keep their order through the queue, rejects included
    skt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // back: table search, update and result register
    skt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .done       (done),
        .result     (result)
    );

endmodule

// ===== rtl/session_key_table_checker.sv =====
// Port-level checker for the session key table, bound to the top level.
// Depends on skt_pkg and session_key_table_assert.svh.
`include "session_key_table_assert.svh"

module session_key_table_props
    import skt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input skt_result_t result
);

    logic status_legal;
    logic is_hit;
    logic is_kept;
    logic data_zero;
    logic slot_zero;

    assign status_legal = result.status inside {ST_STORED, ST_MISMATCH, ST_STALE, ST_HIT,
                                                ST_MISS};
    assign is_hit       = (result.status == ST_HIT);
    assign is_kept      = (result.status == ST_STORED) || (result.status == ST_HIT);
    assign data_zero    = (result.found_authority == 8'd0) && (result.data_key_low == 64'd0)
                          && (result.data_key_high == 64'd0);
    assign slot_zero    = (result.slot_index == 7'd0) && !result.overwrote_full;

    `SKT_ASSERT_IMPLY(a_status_legal, done, status_legal, "illegal status code")

    `SKT_ASSERT_IMPLY(a_nonhit_zero, done && !is_hit, data_zero, "key data on a non-hit result")

    `SKT_ASSERT_IMPLY(a_reject_zero, done && !is_kept, slot_zero, "slot on a reject or miss")

    `SKT_ASSERT_NEVER(a_full_slot0, done && result.overwrote_full && (result.slot_index != 7'd0), "full overwrite not at slot 0")

endmodule

bind session_key_table session_key_table_props u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);
